FILE: rtl/core/akr_pkg.sv
package akr_pkg;

  localparam int TABLE_SLOTS = 8192;
  localparam int MAX_RECORDS = 8192;
  localparam int ADDR_BITS   = 48;

  localparam int KEY_W  = 48;
  localparam int REC_W  = 16;
  localparam int CNT_W  = 14;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int REC_IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  localparam int HALF_SLOTS = TABLE_SLOTS / 2;
  localparam int CLR_DEPTH  = (TABLE_SLOTS > MAX_RECORDS) ? TABLE_SLOTS : MAX_RECORDS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

  localparam logic [63:0] HASH_MUL = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((65'd1 << ADDR_BITS) - 65'd1);

  localparam logic [1:0] CFG_ADDR_RECORD_COUNT = 2'd0;

  typedef enum logic {
    FUNC_BIND   = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_BOUND     = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_LL,
    F_MUL_HL,
    F_MUL_LH,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_REC,
    B_PROBE
  } back_state_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    func_t             func;
    logic [REC_W-1:0]  rec;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic              rec_ok;
    logic              key_zero;
  } work_t;

endpackage

FILE: rtl/core/akr_front.sv
module akr_front
  import akr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hold,
  input  logic [CNT_W-1:0] record_count,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [REC_W-1:0] in_record_number,
  input  logic [KEY_W-1:0] in_key_addr,
  input  logic             q_full,
  output logic             q_push,
  output work_t            q_data
);

  front_state_t      state_r, state_nxt;
  func_t             func_r;
  logic [REC_W-1:0]  rec_r;
  logic [KEY_W-1:0]  key_r;
  logic              rec_ok_r;
  logic [63:0]       x_r;
  logic [63:0]       acc_r, acc_nxt;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [63:0]       hash;
  logic              accept;
  logic [KEY_W-1:0]  key_in;
  logic [63:0]       x_sh;
  logic [63:0]       x_in;
  logic              rec_ok_in;

  assign key_in    = in_key_addr & KEY_MASK;
  assign x_sh      = {{(64 - KEY_W){1'b0}}, key_in} >> 4;
  assign x_in      = x_sh ^ (x_sh >> 33);
  assign rec_ok_in = (in_record_number < {{(REC_W - CNT_W){1'b0}}, record_count}) &&
                     ({1'b0, in_record_number} < (REC_W + 1)'(MAX_RECORDS));

  assign in_stall = (state_r != F_IDLE) || hold;
  assign accept   = in_valid && !in_stall;

  // The 64-bit product modulo 2^64 is built from three 32x32 passes
  // through one shared multiplier.
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};
  assign hash = acc_r ^ (acc_r >> 29);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    mul_a     = x_r[31:0];
    mul_b     = HASH_MUL[31:0];
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MUL_LL;
        end
      end
      F_MUL_LL: begin
        acc_nxt   = prod;
        state_nxt = F_MUL_HL;
      end
      F_MUL_HL: begin
        mul_a     = x_r[63:32];
        acc_nxt   = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
        state_nxt = F_MUL_LH;
      end
      F_MUL_LH: begin
        mul_b     = HASH_MUL[63:32];
        acc_nxt   = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_comb begin
    q_data.func     = func_r;
    q_data.rec      = rec_r;
    q_data.key      = key_r;
    q_data.slot     = hash[SLOT_W-1:0];
    q_data.rec_ok   = rec_ok_r;
    q_data.key_zero = (key_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (accept) begin
      func_r   <= func_t'(in_func);
      rec_r    <= in_record_number;
      key_r    <= key_in;
      rec_ok_r <= rec_ok_in;
      x_r      <= x_in;
    end
  end

endmodule

FILE: rtl/core/akr_fifo.sv
module akr_fifo
  import akr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output work_t pop_data,
  output logic  full,
  output logic  not_empty
);

  work_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PW:0]   cnt_r;

  assign full      = (cnt_r == (FIFO_PW + 1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/akr_back.sv
module akr_back
  import akr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  output logic             clearing,
  input  logic             q_valid,
  input  work_t            q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [KEY_W-1:0] out_bound_addr,
  output logic [REC_W-1:0] out_found_record
);

  logic [KEY_W+REC_W-1:0] slot_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]       rec_mem  [MAX_RECORDS];

  back_state_t            state_r, state_nxt;
  logic [CLR_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  func_t                  func_r, func_nxt;
  logic [REC_W-1:0]       rec_r, rec_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SLOT_W-1:0]      probe_cnt_r, probe_cnt_nxt;
  logic [SLOT_W-1:0]      bound_total_r, bound_total_nxt;

  logic                   slot_we;
  logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
  logic [KEY_W+REC_W-1:0] slot_wdata, slot_rdata_r;
  logic                   rec_we;
  logic [REC_IW-1:0]      rec_waddr, rec_raddr;
  logic [KEY_W-1:0]       rec_wdata, rec_rdata_r;

  logic                   res_fire;
  status_t                res_status;
  logic [KEY_W-1:0]       res_baddr;
  logic [REC_W-1:0]       res_frec;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [KEY_W-1:0]       out_baddr_r;
  logic [REC_W-1:0]       out_frec_r;
  logic                   out_free;
  logic [KEY_W-1:0]       probe_key;
  logic [SLOT_W-1:0]      slot_inc;

  assign clearing  = (state_r == B_CLEAR);
  assign out_free  = !out_valid_r || !out_stall;
  assign probe_key = slot_rdata_r[KEY_W-1:0];
  assign slot_inc  = slot_r + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    func_nxt        = func_r;
    rec_nxt         = rec_r;
    key_nxt         = key_r;
    slot_nxt        = slot_r;
    probe_cnt_nxt   = probe_cnt_r;
    bound_total_nxt = bound_total_r;
    q_pop           = 1'b0;
    slot_we         = 1'b0;
    slot_waddr      = slot_r;
    slot_wdata      = {rec_r, key_r};
    slot_raddr      = slot_r;
    rec_we          = 1'b0;
    rec_waddr       = rec_r[REC_IW-1:0];
    rec_wdata       = key_r;
    rec_raddr       = rec_r[REC_IW-1:0];
    res_fire        = 1'b0;
    res_status      = ST_REJECTED;
    res_baddr       = '0;
    res_frec        = '0;
    case (state_r)
      B_CLEAR: begin
        slot_waddr  = clr_cnt_r[SLOT_W-1:0];
        slot_wdata  = '0;
        slot_we     = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(TABLE_SLOTS));
        rec_waddr   = clr_cnt_r[REC_IW-1:0];
        rec_wdata   = '0;
        rec_we      = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(MAX_RECORDS));
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        // Taking an item only when the output register is free lets every
        // later result of that item land without waiting.
        if (q_valid && out_free) begin
          q_pop         = 1'b1;
          func_nxt      = q_data.func;
          rec_nxt       = q_data.rec;
          key_nxt       = q_data.key;
          slot_nxt      = q_data.slot;
          probe_cnt_nxt = '0;
          slot_raddr    = q_data.slot;
          rec_raddr     = q_data.rec[REC_IW-1:0];
          if (q_data.func == FUNC_BIND) begin
            if (!q_data.rec_ok || (bound_total_r >= SLOT_W'(HALF_SLOTS))) begin
              res_fire   = 1'b1;
              res_status = ST_REJECTED;
            end else begin
              state_nxt = B_REC;
            end
          end else if (q_data.key_zero) begin
            res_fire   = 1'b1;
            res_status = ST_NOT_FOUND;
          end else begin
            state_nxt = B_PROBE;
          end
        end
      end
      B_REC: begin
        if (rec_rdata_r != '0) begin
          res_fire   = 1'b1;
          res_status = ST_BOUND;
          res_baddr  = rec_rdata_r;
          state_nxt  = B_IDLE;
        end else if (key_r == '0) begin
          res_fire   = 1'b1;
          res_status = ST_REJECTED;
          state_nxt  = B_IDLE;
        end else begin
          state_nxt = B_PROBE;
        end
      end
      B_PROBE: begin
        if (probe_key == '0) begin
          res_fire  = 1'b1;
          state_nxt = B_IDLE;
          if (func_r == FUNC_BIND) begin
            slot_we         = 1'b1;
            rec_we          = 1'b1;
            bound_total_nxt = bound_total_r + 1'b1;
            res_status      = ST_INSERTED;
            res_baddr       = key_r;
          end else begin
            res_status = ST_NOT_FOUND;
          end
        end else if ((func_r == FUNC_LOOKUP) && (probe_key == key_r)) begin
          res_fire   = 1'b1;
          res_status = ST_FOUND;
          res_frec   = slot_rdata_r[KEY_W+REC_W-1:KEY_W];
          state_nxt  = B_IDLE;
        end else if (probe_cnt_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          res_fire   = 1'b1;
          res_status = (func_r == FUNC_BIND) ? ST_REJECTED : ST_NOT_FOUND;
          state_nxt  = B_IDLE;
        end else begin
          slot_nxt      = slot_inc;
          slot_raddr    = slot_inc;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_CLEAR;
      clr_cnt_r     <= '0;
      bound_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      bound_total_r <= bound_total_nxt;
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    rec_r       <= rec_nxt;
    key_r       <= key_nxt;
    slot_r      <= slot_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    if (res_fire) begin
      out_status_r <= res_status;
      out_baddr_r  <= res_baddr;
      out_frec_r   <= res_frec;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata_r <= rec_mem[rec_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_bound_addr   = out_baddr_r;
  assign out_found_record = out_frec_r;

endmodule

FILE: rtl/core/address_keyed_linear_probe_registry.sv
// Channel   Direction  Handshake         Payload
// in_       input      in_valid/in_stall    func, record_number, key_addr
// out_      output     out_valid/out_stall  status, bound_addr, found_record
// cfg       input      psel/penable/pready  record_count at byte address 0
//
// The front takes a new item only after pushing the last one: it captures
// the item, makes three passes through one 32x32 multiplier for the hash,
// then writes it into a two-entry queue, waiting while that queue is full.
// The back answers an out-of-range or half-full bind and a zero-key lookup
// straight from idle; a lookup probes slot after slot, and a bind reads its
// record first, then probes, paced by the single read port of the slot memory.
// After reset both memories are cleared; no item is taken during that pass,
// while configuration writes are.
// A stalled result sits in the output register while the front keeps hashing.
module address_keyed_linear_probe_registry
  import akr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [REC_W-1:0] in_record_number,
  input  logic [KEY_W-1:0] in_key_addr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [KEY_W-1:0] out_bound_addr,
  output logic [REC_W-1:0] out_found_record,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CNT_W-1:0] record_count_r;
  logic             cfg_write;
  logic             clearing;
  logic             q_push, q_pop, q_full, q_not_empty;
  work_t            q_push_data, q_pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == CFG_ADDR_RECORD_COUNT);
  assign prdata    = (paddr == CFG_ADDR_RECORD_COUNT) ? {{(32 - CNT_W){1'b0}}, record_count_r}
                                                      : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_count_r <= '0;
    end else if (cfg_write) begin
      record_count_r <= pwdata[CNT_W-1:0];
    end
  end

  akr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .hold             (clearing),
    .record_count     (record_count_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_record_number (in_record_number),
    .in_key_addr      (in_key_addr),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_push_data)
  );

  akr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  akr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clearing         (clearing),
    .q_valid          (q_not_empty),
    .q_data           (q_pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_bound_addr   (out_bound_addr),
    .out_found_record (out_found_record)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import akr_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] addr;
    logic [REC_W-1:0] rec;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_func;
  logic [REC_W-1:0] in_record_number;
  logic [KEY_W-1:0] in_key_addr;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       out_status;
  logic [KEY_W-1:0] out_bound_addr;
  logic [REC_W-1:0] out_found_record;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [1:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // Shadow copy of the registry contents.
  bit [KEY_W-1:0] slot_key [TABLE_SLOTS];
  bit [REC_W-1:0] slot_rec [TABLE_SLOTS];
  bit [KEY_W-1:0] addr_of_rec [MAX_RECORDS];
  int             bound_cnt;
  bit [CNT_W-1:0] rec_limit;

  reply_t           pending_replies[$];
  logic [KEY_W-1:0] bound_keys[$];
  logic [REC_W-1:0] bound_recs[$];
  logic [KEY_W-5:0] cluster_base [8];

  int mismatch_count;
  bit sender_gaps_on;
  bit receiver_gaps_on;
  int stall_burst;

  address_keyed_linear_probe_registry dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_record_number (in_record_number),
    .in_key_addr      (in_key_addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_bound_addr   (out_bound_addr),
    .out_found_record (out_found_record),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [63:0] x;
    x = {16'b0, key} >> 4;
    x = x ^ (x >> 33);
    x = x * HASH_MUL;
    x = x ^ (x >> 29);
    return x[SLOT_W-1:0];
  endfunction

  function automatic reply_t registry_apply(input func_t f, input logic [REC_W-1:0] rec,
                                            input logic [KEY_W-1:0] key_in);
    reply_t            r;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] home;
    logic [SLOT_W-1:0] idx;
    bit                probe;
    bit                done;
    int                i;
    key = key_in & KEY_MASK;
    home = home_slot(key);
    r = '0;
    probe = 1'b0;
    done = 1'b0;
    if (f == FUNC_BIND) begin
      r.status = ST_REJECTED;
      if (rec >= rec_limit || rec >= MAX_RECORDS || bound_cnt >= HALF_SLOTS) begin
        r.status = ST_REJECTED;
      end else if (addr_of_rec[rec] != 0) begin
        r.status = ST_BOUND;
        r.addr = addr_of_rec[rec];
      end else begin
        probe = (key != 0);
      end
    end else begin
      r.status = ST_NOT_FOUND;
      probe = (key != 0);
    end
    if (probe) begin
      for (i = 0; i < TABLE_SLOTS && !done; i++) begin
        idx = home + SLOT_W'(i);
        if (f == FUNC_BIND) begin
          if (slot_key[idx] == 0) begin
            slot_key[idx] = key;
            slot_rec[idx] = rec;
            addr_of_rec[rec] = key;
            bound_cnt++;
            r.status = ST_INSERTED;
            r.addr = key;
            done = 1'b1;
          end
        end else if (slot_key[idx] == 0) begin
          done = 1'b1;
        end else if (slot_key[idx] == key) begin
          r.status = ST_FOUND;
          r.rec = slot_rec[idx];
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Keys that share everything above the low nibble hash to the same slot.
  function automatic logic [KEY_W-1:0] clustered_key();
    return {cluster_base[$urandom_range(0, 7)], 4'($urandom)};
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  task automatic send_item(input func_t f, input logic [REC_W-1:0] rec,
                           input logic [KEY_W-1:0] key);
    int     gap;
    reply_t reply;
    gap = sender_gaps_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func <= f;
    in_record_number <= rec;
    in_key_addr <= key;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reply = registry_apply(f, rec, key);
    pending_replies.push_back(reply);
    if (reply.status == ST_INSERTED) begin
      bound_keys.push_back(key & KEY_MASK);
      bound_recs.push_back(rec);
    end
  endtask

  task automatic wait_all_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Write record_count, then read it back in a second transfer.
  task automatic cfg_write(input logic [CNT_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_RECORD_COUNT;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rec_limit = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CNT_W-1:0] !== value) begin
      $error("record_count: expected %0d, got %0d", value, prdata[CNT_W-1:0]);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(FUNC_BIND, 16'd0, 48'h0000_dead_beef);
    send_item(FUNC_LOOKUP, 16'd0, 48'h0000_dead_beef);
    wait_all_replies();
  endtask

  task automatic test_directed_cases();
    cfg_write(CNT_W'(MAX_RECORDS));
    send_item(FUNC_BIND, 16'd0, 48'hffff_ffff_ffff);
    send_item(FUNC_BIND, 16'd0, 48'h0000_0000_5555);
    send_item(FUNC_BIND, 16'd0, 48'h0);
    send_item(FUNC_BIND, 16'd1, 48'h0);
    send_item(FUNC_BIND, REC_W'(MAX_RECORDS - 1), 48'h1);
    send_item(FUNC_BIND, REC_W'(MAX_RECORDS), 48'h2);
    send_item(FUNC_BIND, 16'hffff, 48'h3);
    // A second record carrying a key that is already in the table.
    send_item(FUNC_BIND, 16'd2, 48'hffff_ffff_ffff);
    send_item(FUNC_LOOKUP, 16'hffff, 48'hffff_ffff_ffff);
    send_item(FUNC_BIND, 16'd3, 48'h1230);
    send_item(FUNC_BIND, 16'd4, 48'h1235);
    send_item(FUNC_BIND, 16'd5, 48'h123f);
    send_item(FUNC_LOOKUP, 16'd0, 48'h1235);
    send_item(FUNC_LOOKUP, 16'd0, 48'h123f);
    send_item(FUNC_LOOKUP, 16'd0, 48'h123a);
    send_item(FUNC_LOOKUP, 16'd0, 48'h0);
    send_item(FUNC_LOOKUP, 16'hffff, 48'h1);
    wait_all_replies();
    cfg_write(CNT_W'(1));
    send_item(FUNC_BIND, 16'd0, 48'h7);
    send_item(FUNC_BIND, 16'd1, 48'h8);
    wait_all_replies();
    cfg_write(CNT_W'(0));
    send_item(FUNC_BIND, 16'd0, 48'h9);
    wait_all_replies();
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] limits [4];
    logic [63:0]      r;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
    func_t            f;
    int               pick;
    int               span;
    limits[0] = CNT_W'(MAX_RECORDS);
    limits[1] = CNT_W'($urandom_range(1, MAX_RECORDS));
    limits[2] = CNT_W'(MAX_RECORDS - 1);
    limits[3] = CNT_W'($urandom_range(1, 64));
    for (int phase = 0; phase < 4; phase++) begin
      wait_all_replies();
      cfg_write(limits[phase]);
      sender_gaps_on = (phase != 1);
      receiver_gaps_on = (phase != 2);
      repeat (325) begin
        r = {$urandom, $urandom};
        span = (rec_limit > MAX_RECORDS) ? MAX_RECORDS : rec_limit;
        pick = $urandom_range(0, 99);
        f = FUNC_BIND;
        rec = REC_W'($urandom);
        key = r[KEY_W-1:0];
        if (pick < 35) begin
          rec = (span > 0) ? REC_W'($urandom_range(0, span - 1)) : '0;
          if (r[63]) key = clustered_key();
        end else if (pick < 65) begin
          f = FUNC_LOOKUP;
          if (bound_keys.size() > 0) key = bound_keys[$urandom_range(0, bound_keys.size() - 1)];
        end else if (pick < 75) begin
          f = FUNC_LOOKUP;
          if (r[62]) key = clustered_key();
        end else if (pick < 85) begin
          if (bound_recs.size() > 0) rec = bound_recs[$urandom_range(0, bound_recs.size() - 1)];
          if (r[61]) key = '0;
        end else begin
          f = func_t'(r[60]);
          rec = r[63:48];
          if (r[59]) key = '0;
        end
        send_item(f, rec, key);
      end
    end
    wait_all_replies();
    sender_gaps_on = 1'b1;
    receiver_gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the block fills up and has to stall its input.
  task automatic test_backpressure();
    cfg_write(CNT_W'(MAX_RECORDS));
    sender_gaps_on = 1'b0;
    stall_burst = 400;
    repeat (40) begin
      if ($urandom_range(0, 1))
        send_item(FUNC_BIND, REC_W'($urandom_range(0, MAX_RECORDS - 1)), clustered_key());
      else
        send_item(FUNC_LOOKUP, REC_W'($urandom), clustered_key());
    end
    wait_all_replies();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_half_full();
    logic [KEY_W-1:0] key;
    int               rec;
    cfg_write(CNT_W'(MAX_RECORDS));
    sender_gaps_on = 1'b0;
    receiver_gaps_on = 1'b0;
    for (rec = 0; rec < MAX_RECORDS && bound_cnt < HALF_SLOTS; rec++) begin
      key = random_key();
      if (key == 0) key = 1;
      send_item(FUNC_BIND, REC_W'(rec), key);
    end
    sender_gaps_on = 1'b1;
    receiver_gaps_on = 1'b1;
    // Once half the slots are taken, every bind is turned away.
    send_item(FUNC_BIND, REC_W'(rec % MAX_RECORDS), random_key());
    send_item(FUNC_BIND, bound_recs[0], random_key());
    repeat (40) begin
      if ($urandom_range(0, 1))
        send_item(FUNC_LOOKUP, REC_W'($urandom),
                  bound_keys[$urandom_range(0, bound_keys.size() - 1)]);
      else
        send_item(FUNC_LOOKUP, REC_W'($urandom), random_key());
    end
    wait_all_replies();
  endtask

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = receiver_gaps_on ? $urandom_range(0, 11) : 0;
      if (stall_burst > 0) begin
        n = stall_burst;
        stall_burst = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with no result expected: status %0d", out_status);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_bound_addr !== want.addr) begin
          $error("bound_addr: expected %h, got %h", want.addr, out_bound_addr);
          mismatch_count++;
        end
        if (out_found_record !== want.rec) begin
          $error("found_record: expected %0d, got %0d", want.rec, out_found_record);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[address_keyed_linear_probe_registry] ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_record_number = '0;
    in_key_addr = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    bound_cnt = 0;
    rec_limit = '0;
    stall_burst = 0;
    sender_gaps_on = 1'b1;
    receiver_gaps_on = 1'b1;
    foreach (cluster_base[j]) cluster_base[j] = (KEY_W - 4)'({$urandom, $urandom});
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_cases();
    test_random_traffic();
    test_backpressure();
    test_half_full();

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("[address_keyed_linear_probe_registry] OK");
    end else begin
      $display("[address_keyed_linear_probe_registry] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/akr_pkg.sv
rtl/core/akr_front.sv
rtl/core/akr_fifo.sv
rtl/core/akr_back.sv
rtl/core/address_keyed_linear_probe_registry.sv
tb/tb.sv
